// File: rtl/ufcb_pkg.sv
// Shared types and constants of the UART flow-control buffer.
package ufcb_pkg;

  localparam int BYTE_W       = 8;
  localparam int RX_DEPTH_DEF = 64;
  localparam int TX_DEPTH_DEF = 128;

  localparam int FLOW_MODE_W = 2;
  localparam int HIGH_MARK_W = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [BYTE_W-1:0] CH_XON  = 8'h11;
  localparam logic [BYTE_W-1:0] CH_XOFF = 8'h13;

  localparam logic [HIGH_MARK_W-1:0] HIGH_MARK_RST = 7'd44;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FLOW_MODE   = 2'd0,
    CFG_HIGH_MARK   = 2'd1,
    CFG_WAKE_ENABLE = 2'd2
  } cfg_index_t;

  typedef enum logic [FLOW_MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_HW   = 2'd1,
    MODE_SW   = 2'd2,
    MODE_RSVD = 2'd3
  } flow_mode_t;

  typedef enum logic [1:0] {
    CMD_RX_BYTE    = 2'd0,
    CMD_TX_SLOT    = 2'd1,
    CMD_HOST_READ  = 2'd2,
    CMD_HOST_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    FS_IDLE    = 4'b0001,
    FS_STOP    = 4'b0010,
    FS_WAITING = 4'b0100,
    FS_GO      = 4'b1000
  } flow_state_t;

  typedef struct packed {
    logic              line_send_valid;
    logic [BYTE_W-1:0] line_send_byte;
    logic              rts_stop;
    logic              read_valid;
    logic [BYTE_W-1:0] read_byte;
    logic              write_accepted;
    logic              rx_dropped;
    logic              wake;
    logic              tx_request;
  } result_t;

  // Result of one transaction while its buffer read is still in flight.
  typedef struct packed {
    result_t res;
    logic    send_from_mem;
    logic    read_from_mem;
  } pend_t;

endpackage

// File: rtl/uart_flow_control_buffer_top.sv
// Top level of the UART receive/transmit buffer with RTS/CTS and XON/XOFF flow control.
//
//   port group | direction | handshake           | contents
//   in_*       | input     | in_valid / in_stall | command, data_byte, cts_stop
//   out_*      | output    | out_valid/out_stall | one result per input transaction
//   cfg_*      | input     | cfg_wr_en           | flow_mode, high_mark, wake_enable
//
// One transaction is accepted per cycle while in_stall is low; its result waits in the pending register
// while the receive or transmit buffer memory read completes, then moves to the output register.
// Pointers, counts and flow state are updated when a transaction is accepted.
// Reset (synchronous, active low) empties both buffers and restores the registers.
// A stalled output holds its result; input is stalled only once the pipeline is full.
module uart_flow_control_buffer_top #(
  parameter int RX_DEPTH = ufcb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = ufcb_pkg::TX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [ufcb_pkg::BYTE_W-1:0]       in_data_byte,
  input  logic                              in_cts_stop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_line_send_valid,
  output logic [ufcb_pkg::BYTE_W-1:0]       out_line_send_byte,
  output logic                              out_rts_stop,
  output logic                              out_read_valid,
  output logic [ufcb_pkg::BYTE_W-1:0]       out_read_byte,
  output logic                              out_write_accepted,
  output logic                              out_rx_dropped,
  output logic                              out_wake,
  output logic                              out_tx_request,
  input  logic                              cfg_wr_en,
  input  logic [ufcb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ufcb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ufcb_pkg::*;

  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int CMP_W    = (RX_CNT_W > HIGH_MARK_W) ? RX_CNT_W : HIGH_MARK_W;

  // Configuration registers.
  logic [FLOW_MODE_W-1:0] flow_mode_r;
  logic [HIGH_MARK_W-1:0] high_mark_r;
  logic                   wake_enable_r;

  // Buffer and flow-control state.
  logic [RX_PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [RX_CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [TX_PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [TX_CNT_W-1:0] tx_count_r, tx_count_nxt;
  flow_state_t         flow_r, flow_nxt;
  logic                tx_stopped_r, tx_stopped_nxt;
  logic                tx_req_r, tx_req_nxt;
  logic                rts_r, rts_nxt;

  // Pipeline.
  logic    pend_valid_r;
  pend_t   pend_r, pend_nxt;
  logic    out_valid_r;
  result_t out_r, out_nxt;

  logic              in_acc;
  logic              out_free;
  logic              pend_go;
  flow_mode_t        mode;
  cmd_t              cmd;
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;

  assign out_free = !out_valid_r || !out_stall;
  assign pend_go  = pend_valid_r && out_free;
  assign in_stall = pend_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign cmd  = cmd_t'(in_command);
  assign mode = (flow_mode_t'(flow_mode_r) == MODE_RSVD) ? MODE_NONE : flow_mode_t'(flow_mode_r);

  always_comb begin
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    rx_count_nxt   = rx_count_r;
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    tx_count_nxt   = tx_count_r;
    flow_nxt       = flow_r;
    tx_stopped_nxt = tx_stopped_r;
    tx_req_nxt     = tx_req_r;
    rts_nxt        = rts_r;
    pend_nxt       = '0;
    rx_we          = 1'b0;
    rx_re          = 1'b0;
    tx_we          = 1'b0;
    tx_re          = 1'b0;

    if (in_acc) begin
      case (cmd)
        CMD_RX_BYTE: begin
          if (mode == MODE_SW && in_data_byte == CH_XOFF) begin
            tx_stopped_nxt = 1'b1;
          end else if (mode == MODE_SW && in_data_byte == CH_XON) begin
            tx_stopped_nxt = 1'b0;
          end else begin
            if (rx_count_r != RX_CNT_W'(RX_DEPTH)) begin
              rx_we             = 1'b1;
              rx_tail_nxt       = (rx_tail_r == RX_PTR_W'(RX_DEPTH - 1)) ? '0
                                  : rx_tail_r + RX_PTR_W'(1);
              rx_count_nxt      = rx_count_r + RX_CNT_W'(1);
              pend_nxt.res.wake = wake_enable_r;
            end else begin
              pend_nxt.res.rx_dropped = 1'b1;
            end
            // The high-mark check sees the count after this byte.
            if (mode != MODE_NONE && (flow_r == FS_IDLE || flow_r == FS_GO) &&
                CMP_W'(rx_count_nxt) > CMP_W'(high_mark_r)) begin
              flow_nxt   = FS_STOP;
              tx_req_nxt = 1'b1;
            end
          end
        end
        CMD_TX_SLOT: begin
          if (mode == MODE_HW) begin
            tx_stopped_nxt = in_cts_stop;
          end
          if (flow_r == FS_STOP) begin
            if (mode == MODE_SW) begin
              pend_nxt.res.line_send_valid = 1'b1;
              pend_nxt.res.line_send_byte  = CH_XOFF;
            end else if (mode == MODE_HW) begin
              rts_nxt = 1'b1;
            end
            flow_nxt = FS_WAITING;
          end else if (flow_r == FS_GO) begin
            if (mode == MODE_SW) begin
              pend_nxt.res.line_send_valid = 1'b1;
              pend_nxt.res.line_send_byte  = CH_XON;
            end else if (mode == MODE_HW) begin
              rts_nxt = 1'b0;
            end
            flow_nxt = FS_IDLE;
          end else if (!tx_stopped_nxt) begin
            if (tx_count_r != '0) begin
              tx_re                        = 1'b1;
              pend_nxt.send_from_mem       = 1'b1;
              pend_nxt.res.line_send_valid = 1'b1;
              tx_head_nxt  = (tx_head_r == TX_PTR_W'(TX_DEPTH - 1)) ? '0
                             : tx_head_r + TX_PTR_W'(1);
              tx_count_nxt = tx_count_r - TX_CNT_W'(1);
            end else begin
              tx_req_nxt = 1'b0;
            end
          end
        end
        CMD_HOST_READ: begin
          if (rx_count_r != '0) begin
            rx_re                   = 1'b1;
            pend_nxt.read_from_mem  = 1'b1;
            pend_nxt.res.read_valid = 1'b1;
            rx_head_nxt  = (rx_head_r == RX_PTR_W'(RX_DEPTH - 1)) ? '0
                           : rx_head_r + RX_PTR_W'(1);
            rx_count_nxt = rx_count_r - RX_CNT_W'(1);
          end else if (flow_r == FS_WAITING) begin
            flow_nxt   = FS_GO;
            tx_req_nxt = 1'b1;
          end
        end
        CMD_HOST_WRITE: begin
          if (tx_count_r != TX_CNT_W'(TX_DEPTH)) begin
            tx_we                       = 1'b1;
            pend_nxt.res.write_accepted = 1'b1;
            tx_tail_nxt  = (tx_tail_r == TX_PTR_W'(TX_DEPTH - 1)) ? '0
                           : tx_tail_r + TX_PTR_W'(1);
            tx_count_nxt = tx_count_r + TX_CNT_W'(1);
            tx_req_nxt   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    pend_nxt.res.rts_stop   = rts_nxt;
    pend_nxt.res.tx_request = tx_req_nxt;
  end

  ufcb_ram #(
    .DEPTH  (RX_DEPTH),
    .ADDR_W (RX_PTR_W)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_we),
    .wr_addr (rx_tail_r),
    .wr_data (in_data_byte),
    .rd_en   (rx_re),
    .rd_addr (rx_head_r),
    .rd_data (rx_rd_data)
  );

  ufcb_ram #(
    .DEPTH  (TX_DEPTH),
    .ADDR_W (TX_PTR_W)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_we),
    .wr_addr (tx_tail_r),
    .wr_data (in_data_byte),
    .rd_en   (tx_re),
    .rd_addr (tx_head_r),
    .rd_data (tx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_mode_r   <= MODE_NONE;
      high_mark_r   <= HIGH_MARK_RST;
      wake_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_FLOW_MODE:   flow_mode_r   <= cfg_data[FLOW_MODE_W-1:0];
        CFG_HIGH_MARK:   high_mark_r   <= cfg_data[HIGH_MARK_W-1:0];
        CFG_WAKE_ENABLE: wake_enable_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      rx_count_r   <= '0;
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      tx_count_r   <= '0;
      flow_r       <= FS_IDLE;
      tx_stopped_r <= 1'b0;
      tx_req_r     <= 1'b0;
      rts_r        <= 1'b0;
    end else begin
      rx_head_r    <= rx_head_nxt;
      rx_tail_r    <= rx_tail_nxt;
      rx_count_r   <= rx_count_nxt;
      tx_head_r    <= tx_head_nxt;
      tx_tail_r    <= tx_tail_nxt;
      tx_count_r   <= tx_count_nxt;
      flow_r       <= flow_nxt;
      tx_stopped_r <= tx_stopped_nxt;
      tx_req_r     <= tx_req_nxt;
      rts_r        <= rts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_valid_r <= 1'b1;
      end else if (pend_go) begin
        pend_valid_r <= 1'b0;
      end
      if (pend_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_r <= pend_nxt;
    end
  end

  // The memory read data is held while the pending transaction waits.
  always_comb begin
    out_nxt = pend_r.res;
    if (pend_r.send_from_mem) begin
      out_nxt.line_send_byte = tx_rd_data;
    end
    if (pend_r.read_from_mem) begin
      out_nxt.read_byte = rx_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_send_valid = out_r.line_send_valid;
  assign out_line_send_byte  = out_r.line_send_byte;
  assign out_rts_stop        = out_r.rts_stop;
  assign out_read_valid      = out_r.read_valid;
  assign out_read_byte       = out_r.read_byte;
  assign out_write_accepted  = out_r.write_accepted;
  assign out_rx_dropped      = out_r.rx_dropped;
  assign out_wake            = out_r.wake;
  assign out_tx_request      = out_r.tx_request;

endmodule

// File: rtl/ufcb_ram.sv
// Byte-wide synchronous buffer memory with one write port and a registered read port.
module ufcb_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [ufcb_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [ufcb_pkg::BYTE_W-1:0] rd_data
);
  import ufcb_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
